// ===== hw/rtl/dltq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-list timer queue package
// Shared types and constants for the timer queue core.
// ----------------------------------------------------------------------------
package dltq_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_REGISTER = 3'd1;
    localparam logic [2:0] OP_REMOVE   = 3'd2;
    localparam logic [2:0] OP_DISPATCH = 3'd3;
    localparam logic [2:0] OP_CLEAR    = 3'd4;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_ID  = 2'd2;
    localparam logic [1:0] ST_NOT_DUE = 2'd3;

    localparam logic [1:0] MODE_FREE   = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_DUE    = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] start_delay;
        logic [31:0] repeat_period;
        logic [15:0] handler_ref;
        logic [31:0] user_arg;
        logic [4:0]  timer_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  assigned_id;
        logic        fired;
        logic [15:0] fired_handler;
        logic [31:0] fired_arg;
    } t_out_item;

endpackage

// ===== hw/rtl/delta_list_timer_queue_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delta-list timer queue core
// Timer table held as a delta-sorted linked list, walked one entry a cycle.
// Tick results and the bad-id and not-due errors go straight to the output
//   state; register, remove, dispatch and clear-all first search, walk or
//   clear the table. Throughput: one transfer at a time, input stalled.
// Reset: synchronous active low; a clearing pass over all SLOTS entries follows
//   reset and clear-all, one entry per cycle, with the input stalled.
// ----------------------------------------------------------------------------
module delta_list_timer_queue_core #(
    parameter int SLOTS = dltq_pkg::SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  dltq_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output dltq_pkg::t_out_item o_data
);
    import dltq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int RW = $clog2(SLOTS + 1);

    typedef enum logic [10:0] {
        S_CLR   = 11'b00000000001,
        S_IDLE  = 11'b00000000010,
        S_FIND  = 11'b00000000100,
        S_INS   = 11'b00000001000,
        S_INSL  = 11'b00000010000,
        S_INSF  = 11'b00000100000,
        S_UNL   = 11'b00001000000,
        S_UNLL  = 11'b00010000000,
        S_UNLN  = 11'b00100000000,
        S_UNLF  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    logic [15:0]   m_handler [SLOTS];
    logic [31:0]   m_delta   [SLOTS];
    logic [31:0]   m_period  [SLOTS];
    logic [31:0]   m_arg     [SLOTS];
    logic [1:0]    r_mode    [SLOTS];
    logic [RW-1:0] r_link    [SLOTS];

    t_state        r_state;
    logic [RW-1:0] r_head;
    logic [IW-1:0] r_idx;      // clear / free-search counter
    logic [IW-1:0] r_slot;     // entry being inserted or removed
    logic [RW-1:0] r_prev;
    logic [RW-1:0] r_cur;
    logic [31:0]   r_d;
    logic [RW:0]   r_n;
    logic          r_free;     // free slot after unlink
    logic          r_clr_rsp;  // clearing pass owes a response
    t_in_item      r_in;
    t_out_item     r_out;
    logic          r_ovalid;

    logic          cur_ok;
    logic [IW-1:0] cur_i;
    logic [31:0]   cur_delta;
    logic [32:0]   sum;

    assign cur_ok    = (r_cur != '0) && (r_cur <= RW'(SLOTS));
    assign cur_i     = IW'(r_cur - RW'(1));
    assign cur_delta = m_delta[cur_i];
    assign sum       = {1'b0, cur_delta} + {1'b0, m_delta[r_slot]};

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLR) begin
            m_handler[r_idx] <= '0;
            m_delta[r_idx]   <= '0;
            m_period[r_idx]  <= '0;
            m_arg[r_idx]     <= '0;
        end else if (r_state == S_IDLE && i_valid && !o_stall) begin
            if (i_data.op == OP_TICK && r_head != '0) begin
                if (m_delta[IW'(r_head - RW'(1))] == '0) begin
                    if (m_period[IW'(r_head - RW'(1))] != '0) begin
                        m_delta[IW'(r_head - RW'(1))] <= m_period[IW'(r_head - RW'(1))];
                    end
                end else begin
                    m_delta[IW'(r_head - RW'(1))] <= m_delta[IW'(r_head - RW'(1))] - 32'd1;
                end
            end
        end else if (r_state == S_FIND && r_mode[r_idx] == MODE_FREE) begin
            m_handler[r_idx] <= r_in.handler_ref;
            m_period[r_idx]  <= r_in.repeat_period;
            m_arg[r_idx]     <= r_in.user_arg;
        end else if (r_state == S_INSF) begin
            m_delta[r_slot] <= r_d;
            if (cur_ok) begin
                m_delta[cur_i] <= cur_delta - r_d;
            end
        end else if (r_state == S_UNLN) begin
            if (cur_ok) begin
                m_delta[cur_i] <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end
        end else if (r_state == S_UNLF && r_free) begin
            m_handler[r_slot] <= '0;
            m_delta[r_slot]   <= '0;
            m_period[r_slot]  <= '0;
            m_arg[r_slot]     <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_idx     <= '0;
            r_head    <= '0;
            r_ovalid  <= 1'b0;
            r_clr_rsp <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                r_mode[i] <= MODE_FREE;
                r_link[i] <= '0;
            end
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_mode[r_idx] <= MODE_FREE;
                    r_link[r_idx] <= '0;
                    r_head        <= '0;
                    if (r_idx == IW'(SLOTS - 1)) begin
                        r_idx   <= '0;
                        r_state <= r_clr_rsp ? S_OUT : S_IDLE;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_IDLE: begin
                    if (i_valid && !o_stall) begin
                        r_in          <= i_data;
                        r_out         <= '0;
                        r_free        <= 1'b1;
                        r_idx         <= '0;
                        r_state       <= S_OUT;
                        case (i_data.op)
                            OP_TICK: begin
                                if (r_head != '0 &&
                                    m_delta[IW'(r_head - RW'(1))] == '0) begin
                                    r_mode[IW'(r_head - RW'(1))] <= MODE_DUE;
                                end
                            end
                            OP_REGISTER: r_state <= S_FIND;
                            OP_REMOVE: begin
                                if (i_data.timer_id == '0 ||
                                    32'(i_data.timer_id) > 32'(SLOTS) ||
                                    r_mode[IW'(i_data.timer_id - 5'd1)] == MODE_FREE) begin
                                    r_out.status <= ST_BAD_ID;
                                end else begin
                                    r_slot  <= IW'(i_data.timer_id - 5'd1);
                                    r_state <= S_UNL;
                                end
                            end
                            OP_DISPATCH: begin
                                if (r_head == '0 ||
                                    r_mode[IW'(r_head - RW'(1))] != MODE_DUE) begin
                                    r_out.status <= ST_NOT_DUE;
                                end else begin
                                    r_out.fired         <= 1'b1;
                                    r_out.fired_handler <= m_handler[IW'(r_head - RW'(1))];
                                    r_out.fired_arg     <= m_arg[IW'(r_head - RW'(1))];
                                    r_slot              <= IW'(r_head - RW'(1));
                                    if (m_period[IW'(r_head - RW'(1))] == '0) begin
                                        r_state <= S_UNL;
                                    end else begin
                                        r_free  <= 1'b0;
                                        r_head  <= r_link[IW'(r_head - RW'(1))];
                                        r_link[IW'(r_head - RW'(1))] <= '0;
                                        r_mode[IW'(r_head - RW'(1))] <= MODE_ACTIVE;
                                        r_d     <= m_delta[IW'(r_head - RW'(1))];
                                        r_state <= S_INS;
                                    end
                                end
                            end
                            OP_CLEAR: begin
                                r_clr_rsp <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            default: ;
                        endcase
                    end
                end
                S_FIND: begin
                    if (r_mode[r_idx] == MODE_FREE) begin
                        r_mode[r_idx] <= MODE_ACTIVE;
                        r_link[r_idx] <= '0;
                        r_slot        <= r_idx;
                        r_d           <= r_in.start_delay;
                        r_out.assigned_id <= 5'(r_idx) + 5'd1;
                        r_state       <= S_INS;
                    end else if (r_idx == IW'(SLOTS - 1)) begin
                        r_out.status <= ST_FULL;
                        r_state      <= S_OUT;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_INS: begin
                    r_prev  <= '0;
                    r_cur   <= r_head;
                    r_n     <= '0;
                    r_state <= S_INSL;
                end
                S_INSL: begin
                    if (cur_ok && r_n < (RW+1)'(SLOTS) && r_d >= cur_delta) begin
                        r_d    <= r_d - cur_delta;
                        r_prev <= r_cur;
                        r_cur  <= r_link[cur_i];
                        r_n    <= r_n + (RW+1)'(1);
                    end else begin
                        r_state <= S_INSF;
                    end
                end
                S_INSF: begin
                    r_link[r_slot] <= cur_ok ? r_cur : '0;
                    if (r_prev == '0) begin
                        r_head <= RW'(r_slot) + RW'(1);
                    end else begin
                        r_link[IW'(r_prev - RW'(1))] <= RW'(r_slot) + RW'(1);
                    end
                    r_state <= S_OUT;
                end
                S_UNL: begin
                    r_n <= '0;
                    r_cur <= r_head;
                    if (r_head == RW'(r_slot) + RW'(1)) begin
                        r_head  <= r_link[r_slot];
                        r_cur   <= r_link[r_slot];
                        r_state <= S_UNLN;
                    end else begin
                        r_state <= S_UNLL;
                    end
                end
                S_UNLL: begin
                    if (!cur_ok || r_n >= (RW+1)'(SLOTS)) begin
                        r_cur   <= r_link[r_slot];
                        r_state <= S_UNLN;
                    end else if (r_link[cur_i] == RW'(r_slot) + RW'(1)) begin
                        r_link[cur_i] <= r_link[r_slot];
                        r_cur   <= r_link[r_slot];
                        r_state <= S_UNLN;
                    end else begin
                        r_cur <= r_link[cur_i];
                        r_n   <= r_n + (RW+1)'(1);
                    end
                end
                S_UNLN: begin
                    r_link[r_slot] <= '0;
                    r_state        <= S_UNLF;
                end
                S_UNLF: begin
                    r_mode[r_slot] <= MODE_FREE;
                    r_state        <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
